FILE: hdl/nnr_pkg.sv
// nnr_pkg: shared types and constants for nearest_point_within_radius.
// Used by nnr_ctrl, nnr_datapath and the top level; depends on nothing.
package nnr_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int COORD_W     = 24;
    localparam int OUT_IDX_W   = 8;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_INSERTED  = 2'd2,
        ST_REJECTED  = 2'd3
    } t_status;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_QUERY  = 1'b1
    } t_kind;

    localparam logic [1:0] CLASS_NONE = 2'd3;

    typedef struct packed {
        t_kind                      kind;
        logic [2:0]                 level;
        logic [1:0]                 item_class;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [COORD_W-1:0]         radius;
    } t_in;

    typedef struct packed {
        t_status                status;
        logic [OUT_IDX_W-1:0]   index;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the accepted transaction
        logic ins_do;    // append point or reject
        logic rd_issue;  // read next stored point into the pipe
        logic finish;    // settle query result
        logic out_load;  // move result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic scan_ok;   // valid table holding at least one point
        logic rd_last;   // current read index is the last stored point
        logic pipe_busy; // distance pipe still holds points
    } t_dp_stat;

    function automatic logic [OUT_IDX_W-1:0] low_index(input logic [31:0] v);
        return v[OUT_IDX_W-1:0];
    endfunction

endpackage

FILE: hdl/nearest_point_within_radius.sv
// nearest_point_within_radius: per-(level, class) 2D point tables, nearest-point query
// against a radius. Depends on nnr_pkg, nnr_ctrl, nnr_datapath.
// One transaction in flight: no new input is accepted until the last result has moved
// into the output register. A query scan reads one stored point per cycle; an empty or
// invalid table is not scanned.
// Synchronous active-low reset clears entry counts and control, not the point store.
module nearest_point_within_radius #(
    parameter int NUM_LEVELS    = 8,
    parameter int TABLE_ENTRIES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input transaction channel
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nnr_pkg::t_in   i_in_data,
    // result transaction channel
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output nnr_pkg::t_out  o_out_data
);

    nnr_pkg::t_cmd      w_cmd;
    nnr_pkg::t_dp_stat  w_stat;
    nnr_pkg::t_out      w_res;
    logic               w_out_free;

    // Output register: a finished result may sit here while the controller
    // already takes the next input transaction.
    logic               r_out_valid;
    nnr_pkg::t_out      r_out_data;

    assign w_out_free = !r_out_valid || i_out_ready;

    nnr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    nnr_datapath #(
        .NUM_LEVELS    (NUM_LEVELS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_data),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // one transaction in flight: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // a result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    // the distance pipe is empty whenever the block is ready for input
    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_stat.pipe_busy)
        else $error("distance pipe busy while idle");

endmodule

FILE: hdl/nnr_ctrl.sv
// nnr_ctrl: sequencer for inserts and table scans.
// Depends on nnr_pkg (state, command and status types).
module nnr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_free,
    input  nnr_pkg::t_dp_stat  i_stat,
    output logic               o_in_ready,
    output nnr_pkg::t_cmd      o_cmd
);

    nnr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nnr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nnr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = nnr_pkg::S_SCAN;
                end
            end
            nnr_pkg::S_SCAN: begin
                // first cycle after load decides insert vs. query
                if (!i_stat.is_query) begin
                    n_state = nnr_pkg::S_RESULT;
                end else if (!i_stat.scan_ok) begin
                    n_state = nnr_pkg::S_RESULT;
                end else if (i_stat.rd_last) begin
                    n_state = nnr_pkg::S_DRAIN;
                end
            end
            nnr_pkg::S_INSERT: begin
                n_state = nnr_pkg::S_RESULT;
            end
            nnr_pkg::S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = nnr_pkg::S_RESULT;
                end
            end
            nnr_pkg::S_RESULT: begin
                if (i_out_free) begin
                    n_state = nnr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nnr_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            nnr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            nnr_pkg::S_SCAN: begin
                if (!i_stat.is_query) begin
                    o_cmd.ins_do = 1'b1;
                end else if (!i_stat.scan_ok) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                end
            end
            nnr_pkg::S_INSERT: begin
                o_cmd.ins_do = 1'b1;
            end
            nnr_pkg::S_DRAIN: begin
                o_cmd.finish = !i_stat.pipe_busy;
            end
            nnr_pkg::S_RESULT: begin
                o_cmd.out_load = i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/nnr_datapath.sv
// nnr_datapath: point store, entry counts, distance pipe and best tracker.
// Depends on nnr_pkg (payload, command and status types).
module nnr_datapath #(
    parameter int NUM_LEVELS    = 8,
    parameter int TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nnr_pkg::t_in       i_in,
    input  nnr_pkg::t_cmd      i_cmd,
    output nnr_pkg::t_dp_stat  o_stat,
    output nnr_pkg::t_out      o_res
);

    // only levels 0..7 are reachable through the 3-bit level field
    localparam int LEVELS_USED = (NUM_LEVELS < 8) ? NUM_LEVELS : 8;
    localparam int NUM_TABLES  = LEVELS_USED * nnr_pkg::NUM_CLASSES;
    localparam int TAB_W       = $clog2(NUM_TABLES);
    localparam int IDX_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
    localparam int MEM_DEPTH   = NUM_TABLES * (2 ** IDX_W);
    localparam int CW          = nnr_pkg::COORD_W;
    localparam int DW          = CW + 1;        // coordinate difference
    localparam int SQW         = 2 * DW;        // squared difference
    localparam int D2W         = SQW + 1;       // sum of squares
    localparam int R2W         = 2 * CW;        // radius squared

    // captured transaction
    nnr_pkg::t_kind              r_kind;
    logic [TAB_W-1:0]            r_tab;
    logic                        r_tab_ok;
    logic signed [CW-1:0]        r_x, r_y;
    logic [CW-1:0]               r_rad;
    logic [R2W-1:0]              r_r2;

    logic [CNT_W-1:0]            r_cnt [NUM_TABLES];
    logic [2*CW-1:0]             r_mem [MEM_DEPTH];

    logic [CNT_W-1:0]            r_rd_idx;

    // pipe stages
    logic                        r_v0, r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]            r_i0, r_i1, r_i2, r_i3;
    logic signed [CW-1:0]        r_px, r_py;
    logic signed [DW-1:0]        r_dx, r_dy;
    logic [SQW-1:0]              r_sx, r_sy;
    logic [D2W-1:0]              r_d2;

    logic                        r_have;
    logic [D2W-1:0]              r_best;
    logic [IDX_W-1:0]            r_best_i;

    nnr_pkg::t_out               r_res;

    logic [4:0]                  w_tab5;
    logic [CNT_W-1:0]            w_cnt;
    logic                        w_ins_ok;
    logic [TAB_W+IDX_W-1:0]      w_wr_addr, w_rd_addr;
    logic signed [SQW-1:0]       w_sqx, w_sqy;

    // level*3 + class
    assign w_tab5    = {1'b0, i_in.level, 1'b0} + {2'b00, i_in.level}
                     + {3'b000, i_in.item_class};
    assign w_cnt     = r_tab_ok ? r_cnt[r_tab] : '0;
    assign w_ins_ok  = r_tab_ok && (32'(w_cnt) < TABLE_ENTRIES);
    assign w_wr_addr = {r_tab, w_cnt[IDX_W-1:0]};
    assign w_rd_addr = {r_tab, r_rd_idx[IDX_W-1:0]};
    assign w_sqx     = r_dx * r_dx;
    assign w_sqy     = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_in.kind;
            r_tab    <= w_tab5[TAB_W-1:0];
            r_tab_ok <= (32'(i_in.level) < LEVELS_USED)
                        && (i_in.item_class != nnr_pkg::CLASS_NONE);
            r_x      <= i_in.pos_x;
            r_y      <= i_in.pos_y;
            r_rad    <= i_in.radius;
        end
        r_r2 <= r_rad * r_rad;
    end

    // entry counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_cnt[t] <= '0;
            end
        end else if (i_cmd.ins_do && w_ins_ok) begin
            r_cnt[r_tab] <= w_cnt + CNT_W'(1);
        end
    end

    // point store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_do && w_ins_ok) begin
            r_mem[w_wr_addr] <= {r_x, r_y};
        end
        if (i_cmd.rd_issue) begin
            {r_px, r_py} <= r_mem[w_rd_addr];
        end
    end

    // read index and pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_have   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_idx <= '0;
                r_have   <= 1'b0;
            end else begin
                if (i_cmd.rd_issue) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
                // strict less-than keeps the earliest index on ties
                if (r_v3 && (!r_have || r_d2 < r_best)) begin
                    r_have <= 1'b1;
                end
            end
            r_v0 <= i_cmd.rd_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // distance pipe payload
    always_ff @(posedge i_clk) begin
        r_i0 <= r_rd_idx[IDX_W-1:0];
        r_i1 <= r_i0;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_dx <= DW'(r_x) - DW'(r_px);
        r_dy <= DW'(r_y) - DW'(r_py);
        r_sx <= w_sqx;
        r_sy <= w_sqy;
        r_d2 <= {1'b0, r_sx} + {1'b0, r_sy};
        if (r_v3 && (!r_have || r_d2 < r_best)) begin
            r_best   <= r_d2;
            r_best_i <= r_i3;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_do) begin
            if (w_ins_ok) begin
                r_res.status <= nnr_pkg::ST_INSERTED;
                r_res.index  <= nnr_pkg::low_index(32'(w_cnt));
            end else begin
                r_res.status <= nnr_pkg::ST_REJECTED;
                r_res.index  <= '0;
            end
        end else if (i_cmd.finish) begin
            if (r_have && (r_best < D2W'(r_r2))) begin
                r_res.status <= nnr_pkg::ST_FOUND;
                r_res.index  <= nnr_pkg::low_index(32'(r_best_i));
            end else begin
                r_res.status <= nnr_pkg::ST_NOT_FOUND;
                r_res.index  <= '0;
            end
        end
    end

    assign o_stat.is_query  = (r_kind == nnr_pkg::KIND_QUERY);
    assign o_stat.scan_ok   = r_tab_ok && (w_cnt != '0);
    assign o_stat.rd_last   = (CNT_W'(r_rd_idx + CNT_W'(1)) == w_cnt);
    assign o_stat.pipe_busy = r_v0 | r_v1 | r_v2 | r_v3;
    assign o_res            = r_res;

endmodule

FILE: bench/testbench.sv
// Testbench for nearest_point_within_radius: point inserts and radius-limited
// nearest queries, checked against a behavioral predictor. Depends on nnr_pkg.
`timescale 1ns / 100ps

module testbench;

    // Block configuration (DUT runs with its defaults)
    localparam int LEVELS  = 8;
    localparam int ENTRIES = 256;
    localparam int TABLES  = LEVELS * nnr_pkg::NUM_CLASSES;

    localparam int X_MAX = 8388607;
    localparam int X_MIN = -8388608;
    localparam int R_MAX = 16777215;

    // Run shape
    localparam int TARGET_ITEMS  = 900;
    localparam int FIRST_RANDOM  = 350;   // accepted count that ends the first random part
    localparam int HOLD_AFTER    = 60;    // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = ENTRIES + 16;  // longest query latency plus margin
    localparam int CYCLE_LIMIT   = 5000000;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // Input transaction channel
    logic          in_valid = 1'b0;
    logic          o_in_ready;
    nnr_pkg::t_in  in_data  = '0;

    // Result transaction channel
    logic          o_out_valid;
    logic          out_ready = 1'b1;
    nnr_pkg::t_out o_out_data;

    nearest_point_within_radius #(
        .NUM_LEVELS   (LEVELS),
        .TABLE_ENTRIES(ENTRIES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: own copy of the per-(level, class) point tables.
    // ------------------------------------------------------------------
    int unsigned        table_fill [TABLES];
    logic signed [23:0] stored_x   [TABLES][ENTRIES];
    logic signed [23:0] stored_y   [TABLES][ENTRIES];

    // Results still owed by the block, oldest first
    nnr_pkg::t_out awaited_results [$];

    int accepted_count = 0;
    int results_seen   = 0;
    int failures       = 0;
    int n_inserted     = 0;
    int n_rejected     = 0;
    int n_found        = 0;
    int n_missed       = 0;

    logic signed [23:0] corners [4] = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF};

    // Appends one owed result at the tail of the queue.
    function automatic void book_owed(input nnr_pkg::t_out res);
        awaited_results.insert(awaited_results.size(), res);
    endfunction

    // Applies one transaction to the predictor tables and returns the result
    // the block must give. Ties keep the earliest index; the found test is
    // strict, so a distance equal to the radius is a miss.
    function automatic nnr_pkg::t_out apply_request(input nnr_pkg::t_in req);
        nnr_pkg::t_out res;
        int     tbl;
        int     best_i;
        bit     have;
        longint dx, dy, d2, best, lim;
        res.status = nnr_pkg::ST_NOT_FOUND;
        res.index  = '0;
        tbl = -1;
        if (req.level < LEVELS && req.item_class < nnr_pkg::NUM_CLASSES) begin
            tbl = int'(req.level) * nnr_pkg::NUM_CLASSES + int'(req.item_class);
        end
        if (req.kind == nnr_pkg::KIND_INSERT) begin
            if (tbl < 0 || table_fill[tbl] >= ENTRIES) begin
                res.status = nnr_pkg::ST_REJECTED;
            end else begin
                stored_x[tbl][table_fill[tbl]] = req.pos_x;
                stored_y[tbl][table_fill[tbl]] = req.pos_y;
                res.status = nnr_pkg::ST_INSERTED;
                res.index  = 8'(table_fill[tbl]);
                table_fill[tbl]++;
            end
        end else if (tbl >= 0) begin
            have   = 1'b0;
            best   = 0;
            best_i = 0;
            for (int i = 0; i < table_fill[tbl]; i++) begin
                dx = longint'($signed(req.pos_x)) - longint'(stored_x[tbl][i]);
                dy = longint'($signed(req.pos_y)) - longint'(stored_y[tbl][i]);
                d2 = dx * dx + dy * dy;
                if (!have || d2 < best) begin
                    have   = 1'b1;
                    best   = d2;
                    best_i = i;
                end
            end
            lim = longint'(req.radius) * longint'(req.radius);
            if (have && best < lim) begin
                res.status = nnr_pkg::ST_FOUND;
                res.index  = 8'(best_i);
            end
        end
        return res;
    endfunction

    // Radius mix: zero, full scale, anything, and mostly distances near the
    // point spreads used below so that found and not found both show up.
    function automatic logic [23:0] random_radius();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            return '0;
        end else if (roll < 16) begin
            return 24'(R_MAX);
        end else if (roll < 30) begin
            return 24'($urandom);
        end
        return 24'($urandom_range(1, 1 << $urandom_range(1, 14)));
    endfunction

    // Random transaction aimed at the live tables: most coordinates land on or
    // near stored points (duplicates give index ties), the rest anywhere or at corner values.
    function automatic nnr_pkg::t_in random_request();
        nnr_pkg::t_in req;
        int  tbl, n, roll, k, spread;
        req.kind       = ($urandom_range(0, 99) < 42) ? nnr_pkg::KIND_INSERT
                                                      : nnr_pkg::KIND_QUERY;
        req.level      = 3'($urandom_range(0, LEVELS - 1));
        req.item_class = ($urandom_range(0, 19) == 0) ? nnr_pkg::CLASS_NONE
                                                      : 2'($urandom_range(0, 2));
        req.radius     = random_radius();
        n = 0;
        if (req.item_class != nnr_pkg::CLASS_NONE) begin
            tbl = int'(req.level) * nnr_pkg::NUM_CLASSES + int'(req.item_class);
            n   = table_fill[tbl];
        end
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
            req.pos_x = 24'($urandom);
            req.pos_y = 24'($urandom);
        end else if (roll < 30) begin
            req.pos_x = corners[$urandom_range(0, 3)];
            req.pos_y = corners[$urandom_range(0, 3)];
        end else if (n > 0) begin
            k      = $urandom_range(0, n - 1);
            spread = (roll < 45) ? 0 : $urandom_range(1, 2048);
            req.pos_x = stored_x[tbl][k] + 24'(int'($urandom_range(0, 2 * spread)) - spread);
            req.pos_y = stored_y[tbl][k] + 24'(int'($urandom_range(0, 2 * spread)) - spread);
        end else begin
            req.pos_x = 24'(int'($urandom_range(0, 8191)) - 4096);
            req.pos_y = 24'(int'($urandom_range(0, 8191)) - 4096);
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Rows with a typed result are checked against that
    // value; the rest against the predictor.
    // ------------------------------------------------------------------
    typedef struct {
        nnr_pkg::t_kind   kind;
        int               level;
        int               cls;
        int               x;
        int               y;
        int               radius;
        bit               typed;
        nnr_pkg::t_status want_status;
        int               want_index;
    } t_script_row;

    localparam int SCRIPT_LEN = 24;

    t_script_row script [SCRIPT_LEN] = '{
        // empty table after reset
        '{nnr_pkg::KIND_QUERY,  0, 0, 0,     0,      R_MAX,   1'b1, nnr_pkg::ST_NOT_FOUND, 0},
        // corner points, insert ignores radius
        '{nnr_pkg::KIND_INSERT, 0, 0, X_MAX, X_MAX,  R_MAX,   1'b1, nnr_pkg::ST_INSERTED,  0},
        '{nnr_pkg::KIND_INSERT, 0, 0, X_MIN, X_MIN,  0,       1'b1, nnr_pkg::ST_INSERTED,  1},
        // class three has no table
        '{nnr_pkg::KIND_INSERT, 0, 3, 5,     5,      1,       1'b1, nnr_pkg::ST_REJECTED,  0},
        '{nnr_pkg::KIND_QUERY,  0, 3, X_MAX, X_MAX,  R_MAX,   1'b1, nnr_pkg::ST_NOT_FOUND, 0},
        // zero radius never finds, even at distance zero
        '{nnr_pkg::KIND_QUERY,  0, 0, X_MAX, X_MAX,  0,       1'b1, nnr_pkg::ST_NOT_FOUND, 0},
        '{nnr_pkg::KIND_QUERY,  0, 0, X_MAX, X_MAX,  1,       1'b1, nnr_pkg::ST_FOUND,     0},
        '{nnr_pkg::KIND_QUERY,  0, 0, X_MIN, X_MIN,  R_MAX,   1'b1, nnr_pkg::ST_FOUND,     1},
        // equidistant from both corners, distance exactly at full radius
        '{nnr_pkg::KIND_QUERY,  0, 0, X_MAX, X_MIN,  R_MAX,   1'b0, nnr_pkg::ST_FOUND,     0},
        '{nnr_pkg::KIND_QUERY,  0, 0, X_MIN, X_MAX,  R_MAX,   1'b0, nnr_pkg::ST_FOUND,     0},
        // duplicate points: tie keeps the first index
        '{nnr_pkg::KIND_INSERT, 7, 2, 0,     0,      12345,   1'b1, nnr_pkg::ST_INSERTED,  0},
        '{nnr_pkg::KIND_INSERT, 7, 2, 0,     0,      0,       1'b1, nnr_pkg::ST_INSERTED,  1},
        '{nnr_pkg::KIND_INSERT, 7, 2, 256,   -256,   R_MAX,   1'b1, nnr_pkg::ST_INSERTED,  2},
        '{nnr_pkg::KIND_QUERY,  7, 2, 0,     0,      1,       1'b1, nnr_pkg::ST_FOUND,     0},
        '{nnr_pkg::KIND_QUERY,  7, 2, 256,   -256,   1,       1'b1, nnr_pkg::ST_FOUND,     2},
        '{nnr_pkg::KIND_QUERY,  7, 2, 128,   -128,   512,     1'b0, nnr_pkg::ST_FOUND,     0},
        '{nnr_pkg::KIND_QUERY,  7, 1, 0,     0,      R_MAX,   1'b1, nnr_pkg::ST_NOT_FOUND, 0},
        '{nnr_pkg::KIND_INSERT, 5, 1, -1,    1,      7,       1'b1, nnr_pkg::ST_INSERTED,  0},
        '{nnr_pkg::KIND_QUERY,  5, 1, -1,    1,      R_MAX,   1'b1, nnr_pkg::ST_FOUND,     0},
        '{nnr_pkg::KIND_QUERY,  5, 1, X_MAX, X_MIN,  100,     1'b0, nnr_pkg::ST_FOUND,     0},
        '{nnr_pkg::KIND_INSERT, 3, 3, X_MIN, X_MAX,  0,       1'b1, nnr_pkg::ST_REJECTED,  0},
        '{nnr_pkg::KIND_QUERY,  2, 0, 12345, -54321, 777,     1'b1, nnr_pkg::ST_NOT_FOUND, 0},
        '{nnr_pkg::KIND_INSERT, 6, 2, X_MAX, X_MIN,  8388608, 1'b1, nnr_pkg::ST_INSERTED,  0},
        // opposite corner: squared distance beyond any radius
        '{nnr_pkg::KIND_QUERY,  6, 2, X_MIN, X_MAX,  R_MAX,   1'b0, nnr_pkg::ST_FOUND,     0}
    };

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    int burst_left = 1;

    // Offers one transaction, holds it until accepted, books the result it
    // owes, then maybe opens a gap before the next burst.
    task automatic offer(input nnr_pkg::t_in req, input bit typed,
                         input nnr_pkg::t_out typed_want);
        nnr_pkg::t_out owed;
        int   gap;
        in_data  <= req;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        owed = apply_request(req);
        if (typed) begin
            owed = typed_want;
        end
        book_owed(owed);
        accepted_count++;
        case (owed.status)
            nnr_pkg::ST_INSERTED:  n_inserted++;
            nnr_pkg::ST_REJECTED:  n_rejected++;
            nnr_pkg::ST_FOUND:     n_found++;
            default:               n_missed++;
        endcase
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 99);
            if (gap < 30) begin
                gap = 0;                            // back-to-back stretch
            end else if (gap < 95) begin
                gap = $urandom_range(1, 20);
            end else begin
                gap = $urandom_range(21, ENTRIES + 40);  // covers a whole scan
            end
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Sender stands still until every owed result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // Fills one table to capacity, pushes past it, then queries the full
    // table so the scan runs its longest.
    task automatic fill_one_table();
        nnr_pkg::t_in req;
        int  tbl;
        int  k;
        int  cx, cy;
        req.level      = 3'($urandom_range(0, LEVELS - 1));
        req.item_class = 2'($urandom_range(0, nnr_pkg::NUM_CLASSES - 1));
        tbl = int'(req.level) * nnr_pkg::NUM_CLASSES + int'(req.item_class);
        cx  = $urandom_range(0, 65535) - 32768;
        cy  = $urandom_range(0, 65535) - 32768;
        req.kind = nnr_pkg::KIND_INSERT;
        while (table_fill[tbl] < ENTRIES) begin
            req.pos_x  = 24'(cx + $urandom_range(0, 4095) - 2048);
            req.pos_y  = 24'(cy + $urandom_range(0, 4095) - 2048);
            req.radius = 24'($urandom);
            offer(req, 1'b0, '0);
        end
        repeat (3) begin
            req.pos_x = 24'($urandom);
            req.pos_y = 24'($urandom);
            offer(req, 1'b0, '0);
        end
        req.kind = nnr_pkg::KIND_QUERY;
        repeat (12) begin
            k = $urandom_range(0, ENTRIES - 1);
            req.pos_x  = stored_x[tbl][k] + 24'($urandom_range(0, 127) - 64);
            req.pos_y  = stored_y[tbl][k] + 24'($urandom_range(0, 127) - 64);
            req.radius = random_radius();
            offer(req, 1'b0, '0);
        end
        req.radius = 24'(R_MAX);
        offer(req, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        nnr_pkg::t_in  req;
        nnr_pkg::t_out want;
        foreach (table_fill[t]) table_fill[t] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            req.kind       = script[r].kind;
            req.level      = 3'(script[r].level);
            req.item_class = 2'(script[r].cls);
            req.pos_x      = 24'(script[r].x);
            req.pos_y      = 24'(script[r].y);
            req.radius     = 24'(script[r].radius);
            want.status    = script[r].want_status;
            want.index     = 8'(script[r].want_index);
            offer(req, script[r].typed, want);
        end
        wait_drained();

        // random traffic; the long receiver hold-off lands in here
        while (accepted_count < FIRST_RANDOM) offer(random_request(), 1'b0, '0);
        wait_drained();

        // one table to capacity, then more random traffic on top of it
        fill_one_table();
        while (accepted_count < TARGET_ITEMS) offer(random_request(), 1'b0, '0);
        wait_drained();

        // quiet tail: anything the block emits now is unowed and gets flagged
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d transactions: %0d inserts, %0d rejected inserts, %0d queries found,",
                 accepted_count, n_inserted, n_rejected, n_found);
        $display("%0d queries not found; one table filled to capacity; %0d check failures.",
                 n_missed, failures);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: checks each result against the oldest owed one. Ready
    // follows its own pattern, switching among four modes, with one
    // long hold-off that backs the block up into its input.
    // ------------------------------------------------------------------
    initial begin
        nnr_pkg::t_out want;
        int   window_pos;
        int   stall_mode;
        bit   hold_done;
        window_pos = 0;
        stall_mode = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no transaction owed: status %0d index %0d",
                           o_out_data.status, o_out_data.index);
                    failures++;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_out_data.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, o_out_data.status);
                        failures++;
                    end
                    if (o_out_data.index !== want.index) begin
                        $error("index mismatch: expected %0d, actual %0d",
                               want.index, o_out_data.index);
                        failures++;
                    end
                end
                results_seen++;
            end
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                window_pos++;
                if (window_pos == 64) begin
                    window_pos = 0;
                    stall_mode = $urandom_range(0, 3);
                end
                case (stall_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (window_pos % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $error("timeout after %0d cycles, %0d results still owed",
                       cycles, awaited_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
